### rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BSA_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("%m: invariant violated");

// An implication checked in the same cycle outside reset.
`define BSA_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication violated");

`endif

### rtl/bsa_pkg.sv
package bsa_pkg;

    // Pool geometry.
    localparam int SLOTS       = 64;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);

    // The first-fit search looks at one group of slots per cycle.
    localparam int GRP         = 8;
    localparam int GRP_W       = $clog2(GRP);
    localparam int NGRP        = (SLOTS + GRP - 1) / GRP;
    localparam int GRP_CNT_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

    // Field and register widths.
    localparam int BASE_W      = 24;
    localparam int SIZE_W      = 13;
    localparam int ADDR_W      = 25;
    localparam int STAT_W      = 3;
    localparam int FREE_W      = 7;
    localparam int PROD_W      = IDX_W + SIZE_W;
    localparam int DIV_CNT_W   = $clog2(ADDR_W);

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    // Register reset values.
    localparam logic [BASE_W-1:0] BASE_RESET = 24'd11776;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE = 1'd1;

    // Request kinds carried in tuser.
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 3'd0,
        ST_NONE_FREE    = 3'd1,
        ST_NONE_USED    = 3'd2,
        ST_RANGE        = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_RCHK,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    div_init;
        logic    scan;
        logic    mul;
        logic    div_step;
        logic    rel_commit;
        logic    out_load;
        t_status out_code;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic action;
        logic pool_full;
        logic pool_empty;
        logic below_base;
        logic grp_hit;
        logic div_last;
        logic idx_range;
        logic idx_free;
        logic out_busy;
    } t_dp_stat;

endpackage

### rtl/bsa_ctrl.sv
module bsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  bsa_pkg::t_dp_stat  i_stat,
    output bsa_pkg::t_dp_cmd   o_cmd
);

    bsa_pkg::t_state  r_state, n_state;
    bsa_pkg::t_status r_code,  n_code;

    // State and status code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::S_IDLE;
            r_code  <= bsa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_code         = r_code;
        o_cmd          = '0;
        o_cmd.out_code = r_code;
        o_s_tready     = 1'b0;
        case (r_state)
            bsa_pkg::S_IDLE: begin
                // No request is taken while reset is applied.
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bsa_pkg::S_CHECK;
                end
            end
            bsa_pkg::S_CHECK: begin
                if (i_stat.action == bsa_pkg::ACT_ALLOC) begin
                    if (i_stat.pool_full) begin
                        n_code  = bsa_pkg::ST_NONE_FREE;
                        n_state = bsa_pkg::S_RESP;
                    end else begin
                        n_state = bsa_pkg::S_SCAN;
                    end
                end else if (i_stat.pool_empty) begin
                    n_code  = bsa_pkg::ST_NONE_USED;
                    n_state = bsa_pkg::S_RESP;
                end else if (i_stat.below_base) begin
                    n_code  = bsa_pkg::ST_RANGE;
                    n_state = bsa_pkg::S_RESP;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = bsa_pkg::S_DIV;
                end
            end
            bsa_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.grp_hit) begin
                    n_state = bsa_pkg::S_MUL;
                end
            end
            bsa_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_code    = bsa_pkg::ST_OK;
                n_state   = bsa_pkg::S_RESP;
            end
            bsa_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = bsa_pkg::S_RCHK;
                end
            end
            bsa_pkg::S_RCHK: begin
                if (i_stat.idx_range) begin
                    n_code = bsa_pkg::ST_RANGE;
                end else if (i_stat.idx_free) begin
                    n_code = bsa_pkg::ST_ALREADY_FREE;
                end else begin
                    o_cmd.rel_commit = 1'b1;
                    n_code           = bsa_pkg::ST_OK;
                end
                n_state = bsa_pkg::S_RESP;
            end
            bsa_pkg::S_RESP: begin
                // Wait until the output register can take the result.
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bsa_dp.sv
`include "assert_macros.svh"

module bsa_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bsa_pkg::t_dp_cmd                 i_cmd,
    output bsa_pkg::t_dp_stat                o_stat,
    // tdata: release_address [24:0]
    input  logic [bsa_pkg::IN_TDATA_W-1:0]   i_tdata,
    // tuser: action [0]
    input  logic [bsa_pkg::IN_TUSER_W-1:0]   i_tuser,
    input  logic                             i_cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    // tdata: status [2:0], slot_address [27:3], free_slots [34:28]
    output logic [bsa_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int PAD_W = bsa_pkg::NGRP * bsa_pkg::GRP;

    // Configuration and pool state.
    logic [bsa_pkg::BASE_W-1:0]    r_base;
    logic [bsa_pkg::SIZE_W-1:0]    r_size;
    logic [bsa_pkg::SLOTS-1:0]     r_used;
    logic [bsa_pkg::CNT_W-1:0]     r_free;

    // Request and working registers.
    logic                          r_action;
    logic [bsa_pkg::ADDR_W-1:0]    r_addr;
    logic [bsa_pkg::GRP_CNT_W-1:0] r_grp;
    logic [bsa_pkg::IDX_W-1:0]     r_idx;
    logic [bsa_pkg::PROD_W-1:0]    r_prod;
    logic [bsa_pkg::ADDR_W-1:0]    r_dvd;
    logic [bsa_pkg::SIZE_W-1:0]    r_rem;
    logic [bsa_pkg::DIV_CNT_W-1:0] r_cnt;

    // Output register.
    logic                          r_out_valid;
    bsa_pkg::t_status              r_out_status;
    logic [bsa_pkg::ADDR_W-1:0]    r_out_addr;
    logic [bsa_pkg::FREE_W-1:0]    r_out_free;

    logic [bsa_pkg::SIZE_W-1:0]    w_eff;
    logic [PAD_W-1:0]              w_map_pad;
    logic [bsa_pkg::GRP-1:0]       w_grp_bits;
    logic                          w_grp_hit;
    logic [bsa_pkg::GRP_W-1:0]     w_enc;
    logic [bsa_pkg::SIZE_W:0]      w_rem_sh;
    logic [bsa_pkg::SIZE_W:0]      w_diff;
    logic                          w_qbit;
    logic [bsa_pkg::IDX_W-1:0]     w_rel_idx;
    logic [bsa_pkg::ADDR_W-1:0]    w_alloc_addr;

    // A slot size of zero behaves as one.
    assign w_eff = (r_size == '0) ? bsa_pkg::SIZE_W'(1) : r_size;

    // Group search: slots beyond the pool read as used.
    always_comb begin
        w_map_pad                     = '1;
        w_map_pad[bsa_pkg::SLOTS-1:0] = r_used;
        w_grp_bits = w_map_pad[r_grp * bsa_pkg::GRP +: bsa_pkg::GRP];
        w_grp_hit  = ~&w_grp_bits;
        w_enc      = '0;
        for (int i = bsa_pkg::GRP - 1; i >= 0; i--) begin
            if (!w_grp_bits[i]) begin
                w_enc = bsa_pkg::GRP_W'(i);
            end
        end
    end

    // One restoring division step per cycle.
    assign w_rem_sh = {r_rem, r_dvd[bsa_pkg::ADDR_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, w_eff};
    assign w_qbit   = (w_rem_sh >= {1'b0, w_eff});

    assign w_rel_idx    = r_dvd[bsa_pkg::IDX_W-1:0];
    assign w_alloc_addr = bsa_pkg::ADDR_W'(r_base) + bsa_pkg::ADDR_W'(r_prod);

    // Status toward the controller.
    always_comb begin
        o_stat.action     = r_action;
        o_stat.pool_full  = (r_free == '0);
        o_stat.pool_empty = (r_free >= bsa_pkg::CNT_W'(bsa_pkg::SLOTS));
        o_stat.below_base = (r_addr < bsa_pkg::ADDR_W'(r_base));
        o_stat.grp_hit    = w_grp_hit;
        o_stat.div_last   = (r_cnt == bsa_pkg::DIV_CNT_W'(bsa_pkg::ADDR_W - 1));
        o_stat.idx_range  = (r_dvd >= bsa_pkg::ADDR_W'(bsa_pkg::SLOTS));
        o_stat.idx_free   = ~r_used[w_rel_idx];
        o_stat.out_busy   = r_out_valid & ~i_m_tready;
    end

    // Configuration registers, bitmap, free count and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= bsa_pkg::BASE_RESET;
            r_size      <= bsa_pkg::SIZE_RESET;
            r_used      <= '0;
            r_free      <= bsa_pkg::CNT_W'(bsa_pkg::SLOTS);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bsa_pkg::CFG_POOL_BASE: r_base <= i_cfg_data[bsa_pkg::BASE_W-1:0];
                    bsa_pkg::CFG_SLOT_SIZE: r_size <= i_cfg_data[bsa_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.mul) begin
                r_used[r_idx] <= 1'b1;
                r_free        <= r_free - 1'b1;
            end
            if (i_cmd.rel_commit) begin
                r_used[w_rel_idx] <= 1'b0;
                r_free            <= r_free + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, search, multiply and divide registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_tuser[0];
            r_addr   <= i_tdata[bsa_pkg::ADDR_W-1:0];
            r_grp    <= '0;
        end
        if (i_cmd.scan) begin
            if (w_grp_hit) begin
                r_idx <= bsa_pkg::IDX_W'({r_grp, w_enc});
            end else begin
                r_grp <= r_grp + 1'b1;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= bsa_pkg::PROD_W'(r_idx) * bsa_pkg::PROD_W'(w_eff);
        end
        if (i_cmd.div_init) begin
            r_dvd <= r_addr - bsa_pkg::ADDR_W'(r_base);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[bsa_pkg::ADDR_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[bsa_pkg::SIZE_W-1:0] : w_rem_sh[bsa_pkg::SIZE_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_code;
            r_out_free   <= bsa_pkg::FREE_W'(r_free);
            if ((i_cmd.out_code == bsa_pkg::ST_OK) && (r_action == bsa_pkg::ACT_ALLOC)) begin
                r_out_addr <= w_alloc_addr;
            end else begin
                r_out_addr <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = bsa_pkg::OUT_TDATA_W'({r_out_free, r_out_addr, r_out_status});

    // The free count always matches the number of clear bitmap bits.
    `BSA_ASSERT_ALWAYS(a_free_count, i_clk, i_rst_n, ($countones(r_used) + int'(r_free)) == bsa_pkg::SLOTS)
    // A new result never overwrites one that is still waiting.
    `BSA_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !(r_out_valid && !i_m_tready))
    // The search only runs while a free slot exists.
    `BSA_ASSERT_IMPLY(a_scan_has_free, i_clk, i_rst_n, i_cmd.scan, r_free != '0)

endmodule

### rtl/bitmap_slot_allocator_unit.sv
// Bitmap slot allocator: first-fit allocation over a pool of 64 equal slots.
// Requests enter on the s_axis channel (tuser = allocate or release, tdata =
// address to release); each request yields exactly one result on m_axis
// (status, slot address, free count after the request).
// The configuration port sets the pool base address (index 0) and the slot
// size (index 1); write it only while no request is in flight.
// Allocate: the bitmap is searched eight slots per cycle, then the index is
// multiplied by the slot size. Release: the offset from the base is divided
// by the slot size one quotient bit per cycle. A request rejected by the
// first check (pool full on allocate, pool empty or address below base on
// release) goes straight to the response. Requests are handled one at a
// time; the next one is accepted the cycle after the result is loaded into
// the output register.
// Reset clears the bitmap, sets the free count to 64, restores the register
// defaults and holds s_axis_tready low. If the receiver stalls, the result
// holds in the output register and one further request can be accepted and
// processed; its result waits inside the block until the output register drains.
module bitmap_slot_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: release_address [24:0]
    input  logic [bsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: action [0]
    input  logic [bsa_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: status [2:0], slot_address [27:3], free_slots [34:28]
    output logic [bsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    bsa_pkg::t_dp_cmd  w_cmd;
    bsa_pkg::t_dp_stat w_stat;

    // Request sequencing.
    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Bitmap, arithmetic and output register.
    bsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
